// ===== rtl/gbmd_pkg.sv =====
// Shared constants and types for the grid diameter search block.
package gbmd_pkg;
  localparam int unsigned DefMaxRows = 64;
  localparam int unsigned DefMaxCols = 64;
  localparam int unsigned DistW = 12;
  localparam int unsigned CfgW = 7;
  localparam logic [0:0] RegRows = 1'b0;
  localparam logic [0:0] RegCols = 1'b1;
  localparam logic [DistW-1:0] DistLimit = 12'hFFF;

  typedef struct packed {
    logic start;
    logic busy;
  } ctl_t;
endpackage

// ===== rtl/gbmd_search.sv =====
// Breadth-first search engine over the grid, stamp, queue and distance memories.
module gbmd_search #(
  parameter int unsigned MaxRows = gbmd_pkg::DefMaxRows,
  parameter int unsigned MaxCols = gbmd_pkg::DefMaxCols,
  parameter int unsigned AddrW = $clog2(MaxRows * MaxCols + 1),
  parameter int unsigned RowW = $clog2(MaxRows + 1),
  parameter int unsigned ColW = $clog2(MaxCols + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [AddrW-1:0]            wr_addr_i,
  input  logic                        wr_data_i,
  input  gbmd_pkg::ctl_t              ctl_i,
  input  logic [RowW-1:0]             rows_i,
  input  logic [ColW-1:0]             cols_i,
  input  logic [AddrW-1:0]            ncells_i,
  output logic                        done_o,
  output logic [gbmd_pkg::DistW-1:0]  best_o
);
  localparam int unsigned Depth = MaxRows * MaxCols;
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned StampW = AddrW;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_SCAN, S_SCANW, S_POP, S_POPW, S_NB, S_NBW, S_DONE
  } state_e;

  logic             grid_mem [Depth];
  logic [StampW-1:0] stamp_mem [Depth];
  logic [AddrW-1:0] queue_mem [Depth];
  logic [gbmd_pkg::DistW-1:0] dist_mem [Depth];

  state_e state_q;
  logic [AddrW-1:0] src_q, head_q, tail_q, cur_q, nb_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic [StampW-1:0] stamp_q;
  logic [gbmd_pkg::DistW-1:0] d_q, far_q, best_q;
  logic [1:0] k_q;
  logic done_q;

  // single read port per memory, registered
  logic [AddrW-1:0] g_ra, s_ra, q_ra;
  logic g_rd;
  logic [StampW-1:0] s_rd;
  logic [AddrW-1:0] q_rd;
  logic [gbmd_pkg::DistW-1:0] d_rd;
  logic s_we, q_we;
  logic [AddrW-1:0] s_wa, q_wa;
  logic [StampW-1:0] s_wd;
  logic [AddrW-1:0] q_wd;
  logic [gbmd_pkg::DistW-1:0] d_wd;

  // row/column of the queue entry: stored with it
  logic [RowW-1:0] rc_row;
  logic [ColW-1:0] rc_col;
  logic [RowW-1:0] rowq_mem_rd;
  logic [ColW-1:0] colq_mem_rd;
  logic [RowW-1:0] row_mem [Depth];
  logic [ColW-1:0] col_mem [Depth];
  logic [RowW-1:0] w_row;
  logic [ColW-1:0] w_col;
  logic [RowW-1:0] scan_row_q;
  logic [ColW-1:0] scan_col_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) grid_mem[wr_addr_i[IdxW-1:0]] <= wr_data_i;
    g_rd <= grid_mem[g_ra[IdxW-1:0]];
    if (s_we) stamp_mem[s_wa[IdxW-1:0]] <= s_wd;
    s_rd <= stamp_mem[s_ra[IdxW-1:0]];
    if (q_we) begin
      queue_mem[q_wa[IdxW-1:0]] <= q_wd;
      dist_mem[q_wa[IdxW-1:0]] <= d_wd;
    end
    q_rd <= queue_mem[q_ra[IdxW-1:0]];
    d_rd <= dist_mem[q_ra[IdxW-1:0]];
  end

  // neighbour candidate
  logic nb_ok;
  logic [AddrW-1:0] nb_a;
  always_comb begin
    nb_ok = 1'b0;
    nb_a = cur_q;
    case (k_q)
      2'd0: begin nb_ok = ({1'b0, col_q} + 1'b1) < {1'b0, cols_i}; nb_a = cur_q + 1'b1; end
      2'd1: begin nb_ok = col_q != '0; nb_a = cur_q - 1'b1; end
      2'd2: begin nb_ok = ({1'b0, row_q} + 1'b1) < {1'b0, rows_i};
                  nb_a = cur_q + AddrW'(cols_i); end
      default: begin nb_ok = row_q != '0; nb_a = cur_q - AddrW'(cols_i); end
    endcase
  end

  logic visit_new;
  assign visit_new = g_rd && (s_rd != stamp_q);

  always_comb begin
    g_ra = src_q; s_ra = src_q; q_ra = head_q;
    s_we = 1'b0; s_wa = src_q; s_wd = '0;
    q_we = 1'b0; q_wa = tail_q; q_wd = src_q; d_wd = '0;
    case (state_q)
      S_CLR: begin s_we = 1'b1; s_wa = src_q; s_wd = '0; end
      S_SCANW: if (g_rd) begin
        s_we = 1'b1; s_wa = src_q; s_wd = stamp_q + 1'b1;
        q_we = 1'b1; q_wa = '0; q_wd = src_q; d_wd = '0;
      end
      S_NB: begin g_ra = nb_a; s_ra = nb_a; end
      S_NBW: if (visit_new) begin
        s_we = 1'b1; s_wa = nb_q; s_wd = stamp_q;
        q_we = 1'b1; q_wa = tail_q; q_wd = nb_q; d_wd = d_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      src_q <= '0; head_q <= '0; tail_q <= '0; cur_q <= '0; nb_q <= '0;
      row_q <= '0; col_q <= '0; stamp_q <= '0; d_q <= '0; far_q <= '0;
      best_q <= '0; k_q <= '0; done_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_DONE);
      case (state_q)
        S_IDLE: if (ctl_i.start) begin
          src_q <= '0; best_q <= '0; stamp_q <= '0; state_q <= S_CLR;
        end
        S_CLR: begin
          if (src_q + 1'b1 >= ncells_i) begin src_q <= '0; state_q <= S_SCAN; end
          else src_q <= src_q + 1'b1;
        end
        S_SCAN: begin
          if (src_q >= ncells_i) state_q <= S_DONE;
          else state_q <= S_SCANW;
        end
        S_SCANW: begin
          if (g_rd) begin
            stamp_q <= stamp_q + 1'b1;
            head_q <= '0; tail_q <= AddrW'(1); far_q <= '0;
            state_q <= S_POP;
          end else begin
            src_q <= src_q + 1'b1; state_q <= S_SCAN;
          end
        end
        S_POP: begin
          if (head_q >= tail_q) begin
            if (far_q > best_q) best_q <= far_q;
            src_q <= src_q + 1'b1; state_q <= S_SCAN;
          end else state_q <= S_POPW;
        end
        S_POPW: begin
          cur_q <= q_rd; d_q <= d_rd; head_q <= head_q + 1'b1; k_q <= '0;
          row_q <= rc_row; col_q <= rc_col; nb_q <= q_rd; state_q <= S_NB;
        end
        S_NB: begin
          nb_q <= nb_a;
          if (nb_ok) state_q <= S_NBW;
          else begin
            if (k_q == 2'd3) state_q <= S_POP;
            k_q <= k_q + 1'b1;
          end
        end
        S_NBW: begin
          if (visit_new) begin
            tail_q <= tail_q + 1'b1;
            if (d_q + 1'b1 > far_q) far_q <= d_q + 1'b1;
          end
          k_q <= k_q + 1'b1;
          state_q <= (k_q == 2'd3) ? S_POP : S_NB;
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    w_row = scan_row_q; w_col = scan_col_q;
    if (state_q == S_NBW) begin
      w_row = row_q; w_col = col_q;
      case (k_q)
        2'd0: w_col = col_q + 1'b1;
        2'd1: w_col = col_q - 1'b1;
        2'd2: w_row = row_q + 1'b1;
        default: w_row = row_q - 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      row_mem[q_wa[IdxW-1:0]] <= w_row;
      col_mem[q_wa[IdxW-1:0]] <= w_col;
    end
    rowq_mem_rd <= row_mem[q_ra[IdxW-1:0]];
    colq_mem_rd <= col_mem[q_ra[IdxW-1:0]];
  end
  assign rc_row = rowq_mem_rd;
  assign rc_col = colq_mem_rd;

  // raster position of the scan pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q <= '0; scan_col_q <= '0;
    end else if (state_q == S_IDLE) begin
      scan_row_q <= '0; scan_col_q <= '0;
    end else if ((state_q == S_SCANW && !g_rd) || (state_q == S_POP && head_q >= tail_q)) begin
      if ({1'b0, scan_col_q} + 1'b1 >= {1'b0, cols_i}) begin
        scan_col_q <= '0; scan_row_q <= scan_row_q + 1'b1;
      end else scan_col_q <= scan_col_q + 1'b1;
    end
  end

  assign done_o = done_q;
  assign best_o = best_q;
endmodule

// ===== rtl/grid_bfs_max_distance.sv =====
// Top level: cell load, configuration and result register around the search engine.
//  channel | dir | handshake      | payload
//  cell    | in  | valid / stall  | cell_open_i, last_cell_i
//  result  | out | valid / stall  | max_distance_o
//  config  | in  | valid / ready  | cfg_index_i, cfg_data_i
// Cells load one per cycle while in_stall is low. After the last cell the search clears
// the stamp store, then scans every cell and, from each open source, pops the queue and
// probes neighbours; each step reads and then waits on the single memory port of its store.
// Reset is asynchronous; the stamp store is swept at the start of every search run.
// The cell channel stalls from the last cell until the result has been transferred.
module grid_bfs_max_distance #(
  parameter int unsigned MaxRows = gbmd_pkg::DefMaxRows,
  parameter int unsigned MaxCols = gbmd_pkg::DefMaxCols
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cell_open_i,
  input  logic                        last_cell_i,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gbmd_pkg::DistW-1:0]  max_distance_o,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index_i,
  input  logic [gbmd_pkg::CfgW-1:0]   cfg_data_i
);
  localparam int unsigned AddrW = $clog2(MaxRows * MaxCols + 1);
  localparam int unsigned RowW = $clog2(MaxRows + 1);
  localparam int unsigned ColW = $clog2(MaxCols + 1);

  logic [gbmd_pkg::CfgW-1:0] rows_q, cols_q;
  logic [AddrW-1:0] load_q;
  logic busy_q, out_valid_q;
  logic [gbmd_pkg::DistW-1:0] res_q;
  logic [RowW-1:0] rows_c;
  logic [ColW-1:0] cols_c;
  logic [AddrW-1:0] ncells;
  logic in_acc, done;
  logic [gbmd_pkg::DistW-1:0] best;
  gbmd_pkg::ctl_t ctl;

  always_comb begin
    if (rows_q == '0) rows_c = RowW'(1);
    else if (32'(rows_q) > MaxRows) rows_c = RowW'(MaxRows);
    else rows_c = RowW'(rows_q);
    if (cols_q == '0) cols_c = ColW'(1);
    else if (32'(cols_q) > MaxCols) cols_c = ColW'(MaxCols);
    else cols_c = ColW'(cols_q);
  end
  assign ncells = AddrW'(rows_c) * AddrW'(cols_c);

  assign in_stall = busy_q || out_valid_q;
  assign in_acc = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign ctl.start = in_acc && last_cell_i;
  assign ctl.busy = busy_q;

  gbmd_search #(.MaxRows(MaxRows), .MaxCols(MaxCols)) u_search (
    .clk_i, .rst_ni,
    .wr_en_i(in_acc && load_q < ncells), .wr_addr_i(load_q), .wr_data_i(cell_open_i),
    .ctl_i(ctl), .rows_i(rows_c), .cols_i(cols_c), .ncells_i(ncells),
    .done_o(done), .best_o(best)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 7'd64; cols_q <= 7'd64; load_q <= '0;
      busy_q <= 1'b0; out_valid_q <= 1'b0; res_q <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index_i == gbmd_pkg::RegRows) rows_q <= cfg_data_i;
        else cols_q <= cfg_data_i;
      end
      if (in_acc) begin
        if (last_cell_i) begin load_q <= '0; busy_q <= 1'b1; end
        else if (load_q < ncells) load_q <= load_q + 1'b1;
      end
      if (done) begin busy_q <= 1'b0; out_valid_q <= 1'b1; res_q <= best; end
      else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
    end
  end

  assign out_valid = out_valid_q;
  assign max_distance_o = res_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_acc) else $error("cell taken during search");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy_q) else $error("result without search");
  a_start_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.start |=> busy_q && !out_valid_q) else $error("start did not begin search");
endmodule
